// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the port checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is asserted
`define TRS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Concurrent check that also holds through reset
`define TRS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

// ===== hw/rtl/trs_pkg.sv =====
// ---------------------------------------------------------------------------
// trs_pkg
// Shared constants, codes and types of the triangle raster scanner.
// ---------------------------------------------------------------------------
package trs_pkg;

    localparam int GRID_HALF_WIDTH = 40;
    localparam int GRID_TOP        = 25;
    localparam int COORD_BITS      = 10;

    localparam int X_W     = 7;
    localparam int Y_W     = 6;
    localparam int CLASS_W = 2;

    // signed difference of two coordinates, product of two differences,
    // difference of two products, sum of three absolute areas
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int AREA_W = PROD_W + 1;
    localparam int SUM_W  = AREA_W + 2;

    localparam int CFG_IDX_W  = 3;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;
    localparam int M_TDATA_PAD = M_TDATA_W - (CLASS_W + X_W + Y_W);

    typedef enum logic [CLASS_W-1:0] {
        CLASS_BLANK  = 2'd0,
        CLASS_INSIDE = 2'd1,
        CLASS_VAXIS  = 2'd2,
        CLASS_HAXIS  = 2'd3
    } pixel_class_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VA_X = 3'd0,
        REG_VA_Y = 3'd1,
        REG_VB_X = 3'd2,
        REG_VB_Y = 3'd3,
        REG_VC_X = 3'd4,
        REG_VC_Y = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
    } vertices_t;

    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic signed [Y_W-1:0] y;
        logic                  row_end;
        logic                  frame_end;
    } pixel_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] abc_p;
        logic signed [PROD_W-1:0] abc_n;
        logic signed [PROD_W-1:0] abp_p;
        logic signed [PROD_W-1:0] abp_n;
        logic signed [PROD_W-1:0] acp_p;
        logic signed [PROD_W-1:0] acp_n;
        logic signed [PROD_W-1:0] bcp_p;
        logic signed [PROD_W-1:0] bcp_n;
    } products_t;

endpackage

// ===== hw/rtl/trs_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// trs_cfg_regs
// Vertex coordinate registers behind the plain write port.
// ---------------------------------------------------------------------------
module trs_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [trs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [trs_pkg::COORD_BITS-1:0]      cfg_wdata,
    output trs_pkg::vertices_t                  verts
);

    trs_pkg::vertices_t verts_reg;
    trs_pkg::vertices_t verts_next;

    always_comb begin
        verts_next = verts_reg;
        if (cfg_we) begin
            unique case (trs_pkg::cfg_reg_t'(cfg_index))
                trs_pkg::REG_VA_X: verts_next.ax = cfg_wdata;
                trs_pkg::REG_VA_Y: verts_next.ay = cfg_wdata;
                trs_pkg::REG_VB_X: verts_next.bx = cfg_wdata;
                trs_pkg::REG_VB_Y: verts_next.by = cfg_wdata;
                trs_pkg::REG_VC_X: verts_next.cx = cfg_wdata;
                trs_pkg::REG_VC_Y: verts_next.cy = cfg_wdata;
                default:           verts_next = verts_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            verts_reg <= '0;
        end else begin
            verts_reg <= verts_next;
        end
    end

    assign verts = verts_reg;

endmodule

// ===== hw/rtl/trs_scan_ctr.sv =====
// ---------------------------------------------------------------------------
// trs_scan_ctr
// Row/column scan position with row-end and frame-end marks.
// ---------------------------------------------------------------------------
module trs_scan_ctr (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            restart,
    output trs_pkg::pixel_t pixel
);

    localparam logic signed [trs_pkg::X_W-1:0] COL_FIRST =
        trs_pkg::X_W'(-trs_pkg::GRID_HALF_WIDTH);
    localparam logic signed [trs_pkg::X_W-1:0] COL_LAST =
        trs_pkg::X_W'(trs_pkg::GRID_HALF_WIDTH - 1);
    localparam logic signed [trs_pkg::Y_W-1:0] ROW_FIRST =
        trs_pkg::Y_W'(trs_pkg::GRID_TOP);
    localparam logic signed [trs_pkg::Y_W-1:0] ROW_LAST =
        trs_pkg::Y_W'(1 - trs_pkg::GRID_TOP);

    logic signed [trs_pkg::X_W-1:0] col_reg;
    logic signed [trs_pkg::X_W-1:0] col_next;
    logic signed [trs_pkg::Y_W-1:0] row_reg;
    logic signed [trs_pkg::Y_W-1:0] row_next;

    always_comb begin
        pixel.x         = restart ? COL_FIRST : col_reg;
        pixel.y         = restart ? ROW_FIRST : row_reg;
        pixel.row_end   = (pixel.x == COL_LAST);
        pixel.frame_end = pixel.row_end && (pixel.y == ROW_LAST);

        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            if (pixel.row_end) begin
                col_next = COL_FIRST;
                row_next = pixel.frame_end ? ROW_FIRST : pixel.y - trs_pkg::Y_W'(1);
            end else begin
                col_next = pixel.x + trs_pkg::X_W'(1);
                row_next = pixel.y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= COL_FIRST;
            row_reg <= ROW_FIRST;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== hw/rtl/trs_area_mul.sv =====
// ---------------------------------------------------------------------------
// trs_area_mul
// First pipeline stage: edge differences and the eight cross products.
// ---------------------------------------------------------------------------
module trs_area_mul (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  trs_pkg::vertices_t  verts,
    input  trs_pkg::pixel_t     pixel,
    output logic                out_valid,
    input  logic                out_ready,
    output trs_pkg::pixel_t     out_pixel,
    output trs_pkg::products_t  out_prods
);

    localparam int DW = trs_pkg::DIFF_W;
    localparam int PW = trs_pkg::PROD_W;

    logic                valid_reg;
    logic                valid_next;
    trs_pkg::pixel_t     pixel_reg;
    trs_pkg::products_t  prods_reg;
    trs_pkg::products_t  prods_next;

    logic signed [DW-1:0] ax, ay, bx, by, cx, cy, px, py;
    logic signed [DW-1:0] d_bax, d_bay, d_cax, d_cay;
    logic signed [DW-1:0] d_pax, d_pay, d_pbx, d_pby, d_cbx, d_cby;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        ax = DW'(verts.ax);
        ay = DW'(verts.ay);
        bx = DW'(verts.bx);
        by = DW'(verts.by);
        cx = DW'(verts.cx);
        cy = DW'(verts.cy);
        px = DW'(pixel.x);
        py = DW'(pixel.y);

        d_bax = bx - ax;
        d_bay = by - ay;
        d_cax = cx - ax;
        d_cay = cy - ay;
        d_pax = px - ax;
        d_pay = py - ay;
        d_pbx = px - bx;
        d_pby = py - by;
        d_cbx = cx - bx;
        d_cby = cy - by;

        prods_next.abc_p = PW'(d_bax) * PW'(d_cay);
        prods_next.abc_n = PW'(d_cax) * PW'(d_bay);
        prods_next.abp_p = PW'(d_bax) * PW'(d_pay);
        prods_next.abp_n = PW'(d_pax) * PW'(d_bay);
        prods_next.acp_p = PW'(d_cax) * PW'(d_pay);
        prods_next.acp_n = PW'(d_pax) * PW'(d_cay);
        prods_next.bcp_p = PW'(d_cbx) * PW'(d_pby);
        prods_next.bcp_n = PW'(d_pbx) * PW'(d_cby);

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pixel_reg <= pixel;
            prods_reg <= prods_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pixel = pixel_reg;
    assign out_prods = prods_reg;

endmodule

// ===== hw/rtl/trs_classify.sv =====
// ---------------------------------------------------------------------------
// trs_classify
// Second pipeline stage: absolute areas, area-sum test, pixel class and
// the output register of the result stream.
// ---------------------------------------------------------------------------
module trs_classify (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  trs_pkg::pixel_t                     pixel,
    input  trs_pkg::products_t                  prods,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [trs_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast,
    output logic                                m_tuser
);

    localparam int AW = trs_pkg::AREA_W;
    localparam int SW = trs_pkg::SUM_W;

    function automatic logic [AW-1:0] area_abs(
        input logic signed [trs_pkg::PROD_W-1:0] p,
        input logic signed [trs_pkg::PROD_W-1:0] n
    );
        logic signed [AW-1:0] d;
        d = AW'(p) - AW'(n);
        return d[AW-1] ? AW'(-d) : AW'(d);
    endfunction

    logic                           valid_reg;
    logic                           valid_next;
    logic [trs_pkg::M_TDATA_W-1:0]  tdata_reg;
    logic [trs_pkg::M_TDATA_W-1:0]  tdata_next;
    logic                           tlast_reg;
    logic                           tuser_reg;

    logic [SW-1:0]                  area_abc;
    logic [SW-1:0]                  area_sum;
    trs_pkg::pixel_class_t          pix_class;

    assign in_ready = !valid_reg || m_tready;

    always_comb begin
        area_abc = SW'(area_abs(prods.abc_p, prods.abc_n));
        area_sum = SW'(area_abs(prods.abp_p, prods.abp_n))
                 + SW'(area_abs(prods.acp_p, prods.acp_n))
                 + SW'(area_abs(prods.bcp_p, prods.bcp_n));

        if (area_abc == area_sum) begin
            pix_class = trs_pkg::CLASS_INSIDE;
        end else if (pixel.x == '0) begin
            pix_class = trs_pkg::CLASS_VAXIS;
        end else if (pixel.y == '0) begin
            pix_class = trs_pkg::CLASS_HAXIS;
        end else begin
            pix_class = trs_pkg::CLASS_BLANK;
        end

        tdata_next = {{trs_pkg::M_TDATA_PAD{1'b0}}, pixel.y, pixel.x, pix_class};
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            tdata_reg <= tdata_next;
            tlast_reg <= pixel.row_end;
            tuser_reg <= pixel.frame_end;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;
    assign m_tuser  = tuser_reg;

endmodule

// ===== hw/rtl/triangle_raster_scanner_core.sv =====
// ---------------------------------------------------------------------------
// triangle_raster_scanner_core
// Raster scan of an 80 x 50 grid with a point-in-triangle area-sum test.
// ---------------------------------------------------------------------------
// Each request on the s_ stream makes one pixel on the m_ stream. Bit 0 of
// s_tdata restarts the scan at the top-left pixel before that pixel is made.
// Rows run from 25 down to -24, columns from -40 to 39; the scan wraps
// after the last pixel. m_tlast marks the last pixel of a row, m_tuser the
// last pixel of the frame.
// The triangle vertices are written through cfg_we/cfg_index/cfg_wdata while
// the stream is idle; indexes above 5 are ignored.
// From an accepted request to m_tvalid there are two register stages: one
// for the cross products, one for the area compare and output.
// Throughput is one pixel per cycle while m_tready is high; the product
// multipliers set the stage depth. When m_tready is low the two stages fill
// and s_tready drops after at most two further requests; nothing is lost.
// Reset clears the vertices to 0, empties both stages and puts the scan at
// the top-left pixel; s_tready is low during reset.
// ---------------------------------------------------------------------------
module triangle_raster_scanner_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [trs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [trs_pkg::COORD_BITS-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [trs_pkg::S_TDATA_W-1:0]       s_tdata,   // [0] restart
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [trs_pkg::M_TDATA_W-1:0]       m_tdata,   // [1:0] pixel_class,
                                                           // [8:2] pixel_x,
                                                           // [14:9] pixel_y
    output logic                                m_tlast,   // row_end
    output logic                                m_tuser    // frame_end
);

    trs_pkg::vertices_t  verts;
    trs_pkg::pixel_t     scan_pixel;
    trs_pkg::pixel_t     mul_pixel;
    trs_pkg::products_t  mul_prods;
    logic                mul_in_ready;
    logic                mul_valid;
    logic                cls_ready;
    logic                s_accept;

    assign s_tready = aresetn && mul_in_ready;
    assign s_accept = s_tvalid && s_tready;

    trs_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .verts     (verts)
    );

    trs_scan_ctr u_scan_ctr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (s_accept),
        .restart (s_tdata[0]),
        .pixel   (scan_pixel)
    );

    trs_area_mul u_area_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid && aresetn),
        .in_ready  (mul_in_ready),
        .verts     (verts),
        .pixel     (scan_pixel),
        .out_valid (mul_valid),
        .out_ready (cls_ready),
        .out_pixel (mul_pixel),
        .out_prods (mul_prods)
    );

    trs_classify u_classify (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (mul_valid),
        .in_ready (cls_ready),
        .pixel    (mul_pixel),
        .prods    (mul_prods),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== hw/rtl/trs_port_checker.sv =====
// ---------------------------------------------------------------------------
// trs_port_checker
// Port-level checks of the raster scanner streams, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module trs_port_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [trs_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic                             m_tlast,
    input logic                             m_tuser
);

    // stalled result holds
    `TRS_ASSERT(a_m_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))

    // frame end is always also a row end
    `TRS_ASSERT(a_frame_row, aclk, aresetn, m_tvalid && m_tuser |-> m_tlast)

    // reset empties the pipeline
    `TRS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

    // a new result only after a request has passed both register stages
    `TRS_ASSERT(a_rise_src, aclk, aresetn, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))

    // input backpressure only when both stages are full and stalled
    `TRS_ASSERT(a_bp_cause, aclk, aresetn, !s_tready |-> m_tvalid && !m_tready)

endmodule

bind triangle_raster_scanner_core trs_port_checker u_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
